// File: hw/rtl/fst_pkg.sv
// shared types, constants and character codes for the format string tokenizer
// no dependencies; imported by the interfaces and every module of the block

package fst_pkg;

   localparam int CharWidth  = 8;
   localparam int FieldWidth = 8;
   // next_arg is kept one bit wider than a slot index
   localparam int ArgWidth   = 9;
   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 32;
   localparam logic [CsrAddrWidth-1:0] ArgCountAddr = '0;

   localparam int FifoDepth  = 4;
   localparam int PtrWidth   = $clog2(FifoDepth);
   localparam int CountWidth = $clog2(FifoDepth + 1);

   localparam logic [CharWidth-1:0] CharPercent = 8'h25;
   localparam logic [CharWidth-1:0] CharBslash  = 8'h5C;
   localparam logic [CharWidth-1:0] CharLowerT  = 8'h74;
   localparam logic [CharWidth-1:0] CharLowerN  = 8'h6E;
   localparam logic [CharWidth-1:0] CharQuote   = 8'h22;
   localparam logic [CharWidth-1:0] CharDot     = 8'h2E;
   localparam logic [CharWidth-1:0] CharLowerD  = 8'h64;
   localparam logic [CharWidth-1:0] CharLowerF  = 8'h66;
   localparam logic [CharWidth-1:0] CharLowerS  = 8'h73;
   localparam logic [CharWidth-1:0] CharZero    = 8'h30;
   localparam logic [CharWidth-1:0] CharNine    = 8'h39;
   localparam logic [CharWidth-1:0] CharTab     = 8'h09;
   localparam logic [CharWidth-1:0] CharNewline = 8'h0A;

   typedef enum logic [1:0] {
      KIND_LITERAL = 2'd0,
      KIND_SPEC    = 2'd1,
      KIND_END_OK  = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CONV_INT    = 2'd0,
      CONV_FLOAT  = 2'd1,
      CONV_STRING = 2'd2
   } conv_type;

   typedef enum logic [1:0] {
      FAULT_NONE     = 2'd0,
      FAULT_INVALID  = 2'd1,
      FAULT_TOO_FEW  = 2'd2,
      FAULT_TOO_MANY = 2'd3
   } fault_type;

   typedef enum logic [4:0] {
      PH_TEXT    = 5'b00001,
      PH_PERCENT = 5'b00010,
      PH_ZERO    = 5'b00100,
      PH_WIDTH   = 5'b01000,
      PH_PREC    = 5'b10000
   } phase_type;

   typedef struct packed {
      kind_type               kind;
      logic [CharWidth-1:0]   out_byte;
      conv_type               conv_code;
      logic                   zero_pad;
      logic [FieldWidth-1:0]  field_width;
      logic [FieldWidth-1:0]  digits_after;
      logic [FieldWidth-1:0]  arg_slot;
      fault_type              fault_code;
      logic                   final_result;
   } result_type;

   // results produced by one accepted byte, packed from res0 upward
   typedef struct packed {
      result_type  res0;
      result_type  res1;
      logic [1:0]  count;
   } push_type;

endpackage

// File: hw/rtl/fst_if.sv
// valid/ready channel interfaces for format string bytes and tokenizer results
// depends on fst_pkg for field widths

interface fst_req_if import fst_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CharWidth-1:0]  char_byte;
   logic                  end_of_string;

   modport source (output valid, output char_byte, output end_of_string, input ready);
   modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

interface fst_rsp_if import fst_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             kind;
   logic [CharWidth-1:0]   out_byte;
   logic [1:0]             conv_code;
   logic                   zero_pad;
   logic [FieldWidth-1:0]  field_width;
   logic [FieldWidth-1:0]  digits_after;
   logic [FieldWidth-1:0]  arg_slot;
   logic [1:0]             fault_code;
   logic                   final_result;

   modport source (output valid, output kind, output out_byte, output conv_code,
                   output zero_pad, output field_width, output digits_after,
                   output arg_slot, output fault_code, output final_result,
                   input ready);
   modport sink   (input valid, input kind, input out_byte, input conv_code,
                   input zero_pad, input field_width, input digits_after,
                   input arg_slot, input fault_code, input final_result,
                   output ready);
endinterface

// File: hw/rtl/fst_parser.sv
// parse state registers and the per-byte decode of the format string
// depends on fst_pkg; produces up to two results per accepted byte

module fst_parser import fst_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [CharWidth-1:0]  char_byte,
   input  logic                  end_of_string,
   input  logic [FieldWidth-1:0] arg_count,
   output push_type              push
);

   phase_type             phase_ff, phase_in;
   logic                  esc_ff, esc_in;
   logic                  pad_ff, pad_in;
   logic [FieldWidth-1:0] width_ff, width_in;
   logic [FieldWidth-1:0] prec_ff, prec_in;
   logic [ArgWidth-1:0]   next_arg_ff, next_arg_in;
   logic                  failed_ff, failed_in;

   result_type            prim;
   logic                  prim_valid;
   result_type            fin;
   logic                  fin_valid;
   logic                  is_digit;
   logic [3:0]            digit;
   logic [ArgWidth-1:0]   args_avail;

   function automatic logic [FieldWidth-1:0] accumulate(input logic [FieldWidth-1:0] acc,
                                                        input logic [3:0] d);
      logic [11:0] v;
      v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'h00, d};
      return (v > 12'd255) ? 8'hFF : v[FieldWidth-1:0];
   endfunction

   function automatic result_type literal(input logic [CharWidth-1:0] b);
      result_type r;
      r = '0;
      r.kind = KIND_LITERAL;
      r.out_byte = b;
      return r;
   endfunction

   function automatic result_type error(input fault_type f);
      result_type r;
      r = '0;
      r.kind = KIND_ERROR;
      r.fault_code = f;
      return r;
   endfunction

   assign is_digit   = (char_byte >= CharZero) && (char_byte <= CharNine);
   assign digit      = 4'(char_byte - CharZero);
   assign args_avail = {1'b0, arg_count};

   always_comb begin
      phase_in    = phase_ff;
      esc_in      = esc_ff;
      pad_in      = pad_ff;
      width_in    = width_ff;
      prec_in     = prec_ff;
      next_arg_in = next_arg_ff;
      failed_in   = failed_ff;
      prim        = '0;
      prim_valid  = 1'b0;

      if (!failed_ff) begin
         unique case (phase_ff)
            PH_TEXT: begin
               priority if (char_byte == CharPercent) begin
                  phase_in = PH_PERCENT;
               end else if (char_byte == CharBslash) begin
                  if (esc_ff) begin
                     prim       = literal(CharBslash);
                     prim_valid = 1'b1;
                  end
                  esc_in = !esc_ff;
               end else if (char_byte == CharLowerT) begin
                  prim       = literal(esc_ff ? CharTab : CharLowerT);
                  prim_valid = 1'b1;
                  esc_in     = 1'b0;
               end else if (char_byte == CharLowerN) begin
                  prim       = literal(esc_ff ? CharNewline : CharLowerN);
                  prim_valid = 1'b1;
                  esc_in     = 1'b0;
               end else if (char_byte == CharQuote) begin
                  // an unescaped quote is dropped
                  if (esc_ff) begin
                     prim       = literal(CharQuote);
                     prim_valid = 1'b1;
                     esc_in     = 1'b0;
                  end
               end else begin
                  prim       = literal(char_byte);
                  prim_valid = 1'b1;
               end
            end
            PH_PERCENT, PH_ZERO, PH_WIDTH, PH_PREC: begin
               prim_valid = 1'b1;
               priority if (char_byte == CharLowerD || char_byte == CharLowerF ||
                            char_byte == CharLowerS) begin
                  if (next_arg_ff >= args_avail) begin
                     prim      = error(FAULT_TOO_FEW);
                     failed_in = 1'b1;
                  end else begin
                     prim.kind         = KIND_SPEC;
                     prim.conv_code    = (char_byte == CharLowerD) ? CONV_INT :
                                         (char_byte == CharLowerF) ? CONV_FLOAT : CONV_STRING;
                     prim.zero_pad     = pad_ff;
                     prim.field_width  = width_ff;
                     prim.digits_after = prec_ff;
                     prim.arg_slot     = next_arg_ff[FieldWidth-1:0];
                     next_arg_in       = next_arg_ff + ArgWidth'(1);
                     pad_in            = 1'b0;
                     width_in          = '0;
                     prec_in           = '0;
                     phase_in          = PH_TEXT;
                  end
               end else if (phase_ff == PH_PERCENT && char_byte == CharPercent) begin
                  prim     = literal(CharPercent);
                  phase_in = PH_TEXT;
               end else if (phase_ff == PH_PERCENT && char_byte == CharZero) begin
                  prim_valid = 1'b0;
                  pad_in     = 1'b1;
                  phase_in   = PH_ZERO;
               end else if (phase_ff == PH_PREC) begin
                  if (is_digit) begin
                     prim_valid = 1'b0;
                     prec_in    = accumulate(prec_ff, digit);
                  end else begin
                     prim      = error(FAULT_INVALID);
                     failed_in = 1'b1;
                  end
               end else if (is_digit && (char_byte != CharZero || phase_ff == PH_WIDTH)) begin
                  prim_valid = 1'b0;
                  width_in   = accumulate(width_ff, digit);
                  phase_in   = PH_WIDTH;
               end else if (char_byte == CharDot) begin
                  prim_valid = 1'b0;
                  phase_in   = PH_PREC;
               end else begin
                  prim      = error(FAULT_INVALID);
                  failed_in = 1'b1;
               end
            end
            default: phase_in = PH_TEXT;
         endcase
      end

      // end status uses the state as updated by this byte
      fin       = '0;
      fin_valid = end_of_string && !failed_in;
      if (next_arg_in < args_avail) begin
         fin = error(FAULT_TOO_MANY);
      end else begin
         fin.kind = KIND_END_OK;
      end

      if (end_of_string) begin
         phase_in    = PH_TEXT;
         esc_in      = 1'b0;
         pad_in      = 1'b0;
         width_in    = '0;
         prec_in     = '0;
         next_arg_in = '0;
         failed_in   = 1'b0;
      end
   end

   always_comb begin
      push = '0;
      if (accept) begin
         if (prim_valid) begin
            push.res0 = prim;
            push.res1 = fin;
            push.res0.final_result = !fin_valid;
            push.res1.final_result = 1'b1;
         end else begin
            push.res0 = fin;
            push.res0.final_result = 1'b1;
         end
         push.count = 2'(prim_valid) + 2'(fin_valid);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TEXT;
         esc_ff      <= 1'b0;
         pad_ff      <= 1'b0;
         width_ff    <= '0;
         prec_ff     <= '0;
         next_arg_ff <= '0;
         failed_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         esc_ff      <= esc_in;
         pad_ff      <= pad_in;
         width_ff    <= width_in;
         prec_ff     <= prec_in;
         next_arg_ff <= next_arg_in;
         failed_ff   <= failed_in;
      end
   end

endmodule

// File: hw/rtl/fst_result_fifo.sv
// small result queue that takes up to two results per cycle and hands out one
// depends on fst_pkg for the result type and queue depth

module fst_result_fifo import fst_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  push_type    push,
   input  logic        pop,
   output logic        not_empty,
   output logic        room_two,
   output result_type  head
);

   result_type             mem_ff [FifoDepth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [PtrWidth-1:0]    wr_next;
   logic                   do_pop;

   assign not_empty = (count_ff != '0);
   assign room_two  = (count_ff <= CountWidth'(FifoDepth - 2));
   assign head      = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;
   assign wr_next   = wr_ptr_ff + PtrWidth'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrWidth'(push.count);
      rd_ptr_in = rd_ptr_ff + PtrWidth'(do_pop);
      count_in  = count_ff + CountWidth'(push.count) - CountWidth'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hw/rtl/format_string_tokenizer_core.sv
// top level of the format string tokenizer: csr port, parser and result queue
// depends on fst_pkg, fst_if, fst_parser and fst_result_fifo
// a result enters the result queue as its byte is accepted and shows on rsp_chan once
// the results ahead of it are taken; throughput: one byte per cycle while each byte yields
// at most one result and rsp_chan is ready, since the queue drains one result per cycle
// reset: synchronous; parse state returns to text phase, queue and arg_count clear, no results pending

module format_string_tokenizer_core import fst_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   fst_req_if.sink                  req_chan,
   fst_rsp_if.source                rsp_chan,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CsrAddrWidth-1:0]  csr_paddr,
   input  logic [CsrDataWidth-1:0]  csr_pwdata,
   output logic [CsrDataWidth-1:0]  csr_prdata,
   output logic                     csr_pready
);

   logic [FieldWidth-1:0] arg_count_ff;
   logic                  req_accept;
   logic                  room_two;
   logic                  not_empty;
   push_type              push;
   result_type            head;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ArgCountAddr) ?
                       CsrDataWidth'(arg_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         arg_count_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == ArgCountAddr) begin
         arg_count_ff <= csr_pwdata[FieldWidth-1:0];
      end
   end

   assign req_chan.ready = room_two;
   assign req_accept     = req_chan.valid && room_two;

   fst_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .char_byte     (req_chan.char_byte),
      .end_of_string (req_chan.end_of_string),
      .arg_count     (arg_count_ff),
      .push          (push)
   );

   fst_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_chan.ready),
      .not_empty (not_empty),
      .room_two  (room_two),
      .head      (head)
   );

   assign rsp_chan.valid        = not_empty;
   assign rsp_chan.kind         = head.kind;
   assign rsp_chan.out_byte     = head.out_byte;
   assign rsp_chan.conv_code    = head.conv_code;
   assign rsp_chan.zero_pad     = head.zero_pad;
   assign rsp_chan.field_width  = head.field_width;
   assign rsp_chan.digits_after = head.digits_after;
   assign rsp_chan.arg_slot     = head.arg_slot;
   assign rsp_chan.fault_code   = head.fault_code;
   assign rsp_chan.final_result = head.final_result;

   // nothing is pending right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid right after reset");

   // an end status is always the last result of its byte
   a_end_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.kind == KIND_END_OK) |-> rsp_chan.final_result)
      else $error("end status not marked final");

   // fault codes only travel with error transactions
   a_fault_only_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.fault_code != FAULT_NONE) |->
      (rsp_chan.kind == KIND_ERROR))
      else $error("fault code on a non-error result");

   // a spec token names an argument below the configured count
   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.kind == KIND_SPEC) |-> (rsp_chan.arg_slot < arg_count_ff))
      else $error("spec argument slot out of range");

endmodule

// File: bench/tb_top.sv
// self-checking bench for format_string_tokenizer_core: random and directed format strings
// depends on fst_pkg, fst_if and the tokenizer rtl; holds its own tokenizer model for checks

module tb_top import fst_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [CharWidth-1:0]  char_byte;
      logic                  eos;
      logic                  drain_first;
   } fmt_byte_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CsrAddrWidth-1:0]  csr_paddr;
   logic [CsrDataWidth-1:0]  csr_pwdata;
   logic [CsrDataWidth-1:0]  csr_prdata;
   logic                     csr_pready;

   fst_req_if req_bus ();
   fst_rsp_if rsp_bus ();

   format_string_tokenizer_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   fmt_byte_type byte_queue[$];
   result_type   token_queue[$];

   // tokenizer model state
   phase_type             parse_phase = PH_TEXT;
   logic                  esc_pending = 1'b0;
   logic                  pad_seen = 1'b0;
   logic                  parse_failed = 1'b0;
   logic [FieldWidth-1:0] width_acc = '0;
   logic [FieldWidth-1:0] prec_acc = '0;
   logic [ArgWidth-1:0]   next_slot = '0;
   logic [7:0]            arg_limit = '0;

   int idle_odds = 0;
   int send_gap_left = 0;
   int rsp_stall_left = 0;
   int rsp_hold_left = 0;
   int fail_count = 0;
   int bytes_queued = 0;
   int strings_done = 0;
   int results_checked = 0;
   int specs_checked = 0;
   int faults_checked = 0;
   int settings_used = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [7:0] decimal_step(input logic [7:0] acc, input logic [7:0] ch);
      int sum;
      sum = int'(acc) * 10 + int'(ch) - int'(CharZero);
      return (sum > 255) ? 8'd255 : sum[7:0];
   endfunction

   function automatic result_type literal_token(input logic [7:0] b);
      result_type r;
      r = '0;
      r.kind = KIND_LITERAL;
      r.out_byte = b;
      return r;
   endfunction

   function automatic result_type fault_token(input fault_type f);
      result_type r;
      r = '0;
      r.kind = KIND_ERROR;
      r.fault_code = f;
      return r;
   endfunction

   // advance the model by one byte and queue the tokens it yields
   function automatic void tokenize_byte(input logic [7:0] c, input logic last);
      result_type batch[$];
      result_type tok;
      logic is_digit;
      is_digit = (c >= CharZero) && (c <= CharNine);
      if (!parse_failed) begin
         if (parse_phase == PH_TEXT) begin
            case (c)
               CharPercent: parse_phase = PH_PERCENT;
               CharBslash: begin
                  if (esc_pending) batch.push_back(literal_token(CharBslash));
                  esc_pending = !esc_pending;
               end
               CharLowerT: begin
                  batch.push_back(literal_token(esc_pending ? CharTab : CharLowerT));
                  esc_pending = 1'b0;
               end
               CharLowerN: begin
                  batch.push_back(literal_token(esc_pending ? CharNewline : CharLowerN));
                  esc_pending = 1'b0;
               end
               CharQuote: begin
                  // a bare quote vanishes
                  if (esc_pending) batch.push_back(literal_token(CharQuote));
                  esc_pending = 1'b0;
               end
               default: batch.push_back(literal_token(c));
            endcase
         end else if (c == CharLowerD || c == CharLowerF || c == CharLowerS) begin
            if (next_slot >= {1'b0, arg_limit}) begin
               batch.push_back(fault_token(FAULT_TOO_FEW));
               parse_failed = 1'b1;
            end else begin
               tok = '0;
               tok.kind = KIND_SPEC;
               tok.conv_code = (c == CharLowerD) ? CONV_INT :
                               ((c == CharLowerF) ? CONV_FLOAT : CONV_STRING);
               tok.zero_pad = pad_seen;
               tok.field_width = width_acc;
               tok.digits_after = prec_acc;
               tok.arg_slot = next_slot[FieldWidth-1:0];
               batch.push_back(tok);
               next_slot = next_slot + 1'b1;
               pad_seen = 1'b0;
               width_acc = '0;
               prec_acc = '0;
               parse_phase = PH_TEXT;
            end
         end else if (parse_phase == PH_PERCENT && c == CharPercent) begin
            batch.push_back(literal_token(CharPercent));
            parse_phase = PH_TEXT;
         end else if (parse_phase == PH_PERCENT && c == CharZero) begin
            pad_seen = 1'b1;
            parse_phase = PH_ZERO;
         end else if (parse_phase == PH_PREC && is_digit) begin
            prec_acc = decimal_step(prec_acc, c);
         end else if (parse_phase != PH_PREC && is_digit &&
                      (c != CharZero || parse_phase == PH_WIDTH)) begin
            width_acc = decimal_step(width_acc, c);
            parse_phase = PH_WIDTH;
         end else if (parse_phase != PH_PREC && c == CharDot) begin
            parse_phase = PH_PREC;
         end else begin
            batch.push_back(fault_token(FAULT_INVALID));
            parse_failed = 1'b1;
         end
      end
      if (last) begin
         if (!parse_failed) begin
            if (next_slot < {1'b0, arg_limit}) batch.push_back(fault_token(FAULT_TOO_MANY));
            else begin
               tok = '0;
               tok.kind = KIND_END_OK;
               batch.push_back(tok);
            end
         end
         parse_phase = PH_TEXT;
         esc_pending = 1'b0;
         pad_seen = 1'b0;
         width_acc = '0;
         prec_acc = '0;
         next_slot = '0;
         parse_failed = 1'b0;
         strings_done++;
      end
      if (batch.size() > 0) batch[batch.size()-1].final_result = 1'b1;
      foreach (batch[i]) token_queue.push_back(batch[i]);
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void push_byte(input logic [7:0] b, input logic eos, input logic drain);
      fmt_byte_type item;
      item.char_byte = b;
      item.eos = eos;
      item.drain_first = drain;
      byte_queue.push_back(item);
      bytes_queued++;
   endfunction

   function automatic void push_text(input string s, input logic end_last);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], end_last && (i == s.len() - 1), 1'b0);
   endfunction

   // one format string: literal pieces mixed with specs, sometimes damaged
   function automatic void queue_random_string(input int specs, input bit compact,
                                               input bit drain);
      logic [7:0] text[$];
      logic [7:0] b;
      int lits;
      int n;
      lits = compact ? 2 : $urandom_range(0, 6);
      while (specs > 0 || lits > 0) begin
         if (specs > 0 && (lits == 0 || $urandom_range(0, 1) == 1)) begin
            specs--;
            text.push_back(CharPercent);
            if (!compact) begin
               if ($urandom_range(0, 2) == 0) text.push_back(CharZero);
               n = $urandom_range(0, 3);
               for (int i = 0; i < n; i++)
                  text.push_back(CharZero + 8'((i == 0) ? $urandom_range(1, 9) : $urandom_range(0, 9)));
               if ($urandom_range(0, 1) == 1) begin
                  text.push_back(CharDot);
                  repeat ($urandom_range(0, 3)) text.push_back(CharZero + 8'($urandom_range(0, 9)));
               end
            end
            case ($urandom_range(0, 2))
               0: text.push_back(CharLowerD);
               1: text.push_back(CharLowerF);
               default: text.push_back(CharLowerS);
            endcase
         end else begin
            lits--;
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  // percent and backslash are doubled so they stay literal
                  b = 8'($urandom_range(0, 255));
                  if (b == CharPercent || b == CharBslash) text.push_back(b);
                  text.push_back(b);
               end
               4, 5: begin
                  text.push_back(CharBslash);
                  case ($urandom_range(0, 3))
                     0: text.push_back(CharBslash);
                     1: text.push_back(CharLowerT);
                     2: text.push_back(CharLowerN);
                     default: text.push_back(CharQuote);
                  endcase
               end
               6: begin
                  text.push_back(CharPercent);
                  text.push_back(CharPercent);
               end
               7: text.push_back(CharQuote);
               8: text.push_back(($urandom_range(0, 1) == 1) ? CharLowerT : CharLowerN);
               default: begin
                  // lone backslash: the escape stays armed across this letter unless it is t or n
                  text.push_back(CharBslash);
                  text.push_back(8'h61 + 8'($urandom_range(0, 25)));
               end
            endcase
         end
      end
      if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
      if (!compact && $urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 2))
            0: text.insert($urandom_range(0, text.size()), 8'($urandom_range(0, 255)));
            1: begin
               // string ends inside a spec
               text.push_back(CharPercent);
               repeat ($urandom_range(0, 2)) text.push_back(CharZero + 8'($urandom_range(1, 9)));
            end
            default: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
         endcase
      end
      foreach (text[i]) push_byte(text[i], i == text.size() - 1, drain && i == 0);
   endfunction

   function automatic void fill_random(input int avail, input int nbytes);
      int start;
      int want;
      start = bytes_queued;
      while (bytes_queued - start < nbytes) begin
         want = (avail > 6) ? $urandom_range(0, 6) : avail;
         case ($urandom_range(0, 9))
            0: want++;
            1: if (want > 0) want = $urandom_range(0, want - 1);
            default: ;
         endcase
         queue_random_string(want, 1'b0, 1'b0);
      end
   endfunction

   task automatic set_arg_count(input logic [7:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ArgCountAddr;
      csr_pwdata <= {{(CsrDataWidth-8){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      arg_limit = value;
      settings_used++;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {{(CsrDataWidth-8){1'b0}}, value}) begin
         $error("arg_count readback mismatch: expected %0d, got %0d", value, csr_prdata);
         fail_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (byte_queue.size() != 0 || req_bus.valid || token_queue.size() != 0);
      // bytes that yield nothing may still be in flight
      repeat (8) @(posedge clock);
   endtask

   always @(posedge clock) begin : byte_driver
      fmt_byte_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap_left > 0) begin
            req_bus.valid <= 1'b0;
            send_gap_left <= send_gap_left - 1;
         end else if (byte_queue.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (byte_queue[0].drain_first &&
                      (req_bus.valid || token_queue.size() != 0)) begin
            req_bus.valid <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
            req_bus.valid <= 1'b0;
            send_gap_left <= $urandom_range(0, 17);
         end else begin
            nxt = byte_queue.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.char_byte <= nxt.char_byte;
            req_bus.end_of_string <= nxt.eos;
         end
      end
   end

   always @(posedge clock) begin : token_receiver
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (rsp_stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 17);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : token_monitor
      result_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            tokenize_byte(req_bus.char_byte, req_bus.end_of_string);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (token_queue.size() == 0) begin
               $error("unexpected result transaction, kind %0d", rsp_bus.kind);
               fail_count++;
            end else begin
               want = token_queue.pop_front();
               check_field("kind", want.kind, rsp_bus.kind);
               check_field("out_byte", want.out_byte, rsp_bus.out_byte);
               check_field("conv_code", want.conv_code, rsp_bus.conv_code);
               check_field("zero_pad", want.zero_pad, rsp_bus.zero_pad);
               check_field("field_width", want.field_width, rsp_bus.field_width);
               check_field("digits_after", want.digits_after, rsp_bus.digits_after);
               check_field("arg_slot", want.arg_slot, rsp_bus.arg_slot);
               check_field("fault_code", want.fault_code, rsp_bus.fault_code);
               check_field("final_result", want.final_result, rsp_bus.final_result);
               results_checked++;
               if (want.kind == KIND_SPEC) specs_checked++;
               else if (want.kind == KIND_ERROR) faults_checked++;
            end
         end
      end
   end

   initial begin : run_sequence
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.char_byte = '0;
      req_bus.end_of_string = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed strings with a single argument
      set_arg_count(8'd1);
      idle_odds = 4;
      push_text("%05.2f%%\"", 1'b0);
      push_byte(8'h00, 1'b1, 1'b0);
      push_text("\\t%999s", 1'b1);
      push_text("%d%f", 1'b1);
      push_text("%.q", 1'b1);
      push_text("%4", 1'b1);
      push_byte(8'hFF, 1'b1, 1'b0);
      wait_idle();

      set_arg_count(8'd0);
      idle_odds = 3;
      fill_random(0, 200);
      wait_idle();

      // results held back long enough that the input side backs up
      set_arg_count(8'd3);
      idle_odds = 6;
      fill_random(3, 400);
      rsp_hold_left = 150;
      wait_idle();

      set_arg_count(8'd255);
      idle_odds = 8;
      queue_random_string(255, 1'b1, 1'b0);
      fill_random(255, 80);
      wait_idle();

      // the sender pauses mid-phase until all results are back
      set_arg_count(8'd2);
      idle_odds = 5;
      fill_random(2, 150);
      queue_random_string(2, 1'b0, 1'b1);
      fill_random(2, 150);
      wait_idle();

      set_arg_count(8'($urandom_range(1, 6)));
      idle_odds = 0;
      fill_random(arg_limit, 350);
      wait_idle();

      $display("tokenized %0d strings (%0d bytes) under %0d arg_count settings",
               strings_done, bytes_queued, settings_used);
      $display("checked %0d results: %0d specs and %0d error reports",
               results_checked, specs_checked, faults_checked);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// File: format_string_tokenizer_core.f
hw/rtl/fst_pkg.sv
hw/rtl/fst_if.sv
hw/rtl/fst_parser.sv
hw/rtl/fst_result_fifo.sv
hw/rtl/format_string_tokenizer_core.sv
bench/tb_top.sv
